FILE: sv/vbsleb_pkg.sv
// ----------------------------------------------------------------------------
// vbsleb_pkg
// shared types and constants for the value byte serializer
// ----------------------------------------------------------------------------
package vbsleb_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned DIGIT_W = 7;
    localparam int unsigned BYTE_W  = 8;

    typedef enum logic [2:0] {
        MODE_BYTE   = 3'd0,
        MODE_BE16   = 3'd1,
        MODE_BE32   = 3'd2,
        MODE_BE64   = 3'd3,
        MODE_ULEB32 = 3'd4,
        MODE_ULEB64 = 3'd5,
        MODE_SLEB32 = 3'd6,
        MODE_SLEB64 = 3'd7
    } mode_t;

    localparam logic [BYTE_W-1:0] LEB_MORE = 8'h80;

    typedef struct packed {
        logic [2:0]         mode;
        logic [VALUE_W-1:0] value;
    } src_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } dst_item_t;

endpackage

FILE: sv/value_byte_serializer_leb128.sv
// ----------------------------------------------------------------------------
// value_byte_serializer_leb128
// serializes a 64-bit value as one byte, big-endian 16/32/64, or LEB128
// ----------------------------------------------------------------------------
// One transaction on the source channel carries a format mode and a 64-bit
// value; the block answers with a run of byte transactions on the destination
// channel, the final byte of each run marked by last. Big-endian runs are
// 1, 2, 4 or 8 bytes, LEB128 runs 1 to 5 bytes for the 32-bit forms and 1 to
// 10 bytes for the 64-bit forms. The value sits in one 64-bit shift register
// that moves by one byte (big-endian) or one 7-bit group (LEB128) per cycle
// once the item is loaded, while the sink keeps up. The next item is taken in
// the cycle after the last byte of the previous run lands in the output
// register; no new item is taken while a run is active. Sink stalls simply
// hold the shift register. There is no configuration and no state across items.
module value_byte_serializer_leb128
    import vbsleb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  src_item_t src_data,
    output logic      dst_valid,
    input  logic      dst_ready,
    output dst_item_t dst_data
);

    // which shifting rule the active run follows
    typedef enum logic [1:0] {
        FMT_BE,
        FMT_ULEB,
        FMT_SLEB
    } fmt_t;

    logic               busy_reg, busy_next;
    fmt_t               fmt_reg, fmt_next;
    logic [VALUE_W-1:0] sr_reg, sr_next;
    logic [2:0]         cnt_reg, cnt_next;          // big-endian bytes left after this one
    logic               dst_valid_reg, dst_valid_next;
    dst_item_t          dst_data_reg, dst_data_next;

    logic               accept;
    logic               emit;
    logic [VALUE_W-1:0] rem;                        // remainder after one LEB group
    logic [BYTE_W-1:0]  digit;
    logic               fin;

    assign src_ready = !busy_reg;
    assign accept    = src_valid && src_ready;
    // output register free or being emptied this cycle
    assign emit      = busy_reg && (!dst_valid_reg || dst_ready);

    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;

    // one digit of the active run
    always_comb
    begin
        rem   = '0;
        digit = '0;
        fin   = 1'b0;
        unique case (fmt_reg)
            FMT_BE:
            begin
                digit = sr_reg[VALUE_W-1 -: BYTE_W];
                fin   = (cnt_reg == 3'd0);
            end
            FMT_ULEB:
            begin
                rem   = sr_reg >> DIGIT_W;
                digit = {1'b0, sr_reg[DIGIT_W-1:0]};
                fin   = (rem == '0);
            end
            FMT_SLEB:
            begin
                rem   = {{DIGIT_W{sr_reg[VALUE_W-1]}}, sr_reg[VALUE_W-1:DIGIT_W]};
                digit = {1'b0, sr_reg[DIGIT_W-1:0]};
                // stop once the sign bit of the group agrees with the remainder
                fin   = ((rem == '0) && !digit[DIGIT_W-1]) ||
                        ((rem == '1) && digit[DIGIT_W-1]);
            end
            default:
            begin
                fin = 1'b1;
            end
        endcase
        if (fmt_reg != FMT_BE && !fin)
        begin
            digit = digit | LEB_MORE;
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        fmt_next       = fmt_reg;
        sr_next        = sr_reg;
        cnt_next       = cnt_reg;
        dst_valid_next = dst_valid_reg;
        dst_data_next  = dst_data_reg;

        // sink took the byte and nothing new replaces it
        if (dst_valid_reg && dst_ready)
        begin
            dst_valid_next = 1'b0;
        end

        if (emit)
        begin
            dst_valid_next         = 1'b1;
            dst_data_next.out_byte = digit;
            dst_data_next.last     = fin;
            if (fin)
            begin
                busy_next = 1'b0;
            end
            if (fmt_reg == FMT_BE)
            begin
                sr_next  = sr_reg << BYTE_W;
                cnt_next = cnt_reg - 3'd1;
            end
            else
            begin
                sr_next = rem;
            end
        end

        // load the next item, left-aligning big-endian values
        if (accept)
        begin
            busy_next = 1'b1;
            unique case (mode_t'(src_data.mode))
                MODE_BYTE:
                begin
                    fmt_next = FMT_BE;
                    sr_next  = src_data.value << (VALUE_W - 8);
                    cnt_next = 3'd0;
                end
                MODE_BE16:
                begin
                    fmt_next = FMT_BE;
                    sr_next  = src_data.value << (VALUE_W - 16);
                    cnt_next = 3'd1;
                end
                MODE_BE32:
                begin
                    fmt_next = FMT_BE;
                    sr_next  = src_data.value << (VALUE_W - 32);
                    cnt_next = 3'd3;
                end
                MODE_BE64:
                begin
                    fmt_next = FMT_BE;
                    sr_next  = src_data.value;
                    cnt_next = 3'd7;
                end
                MODE_ULEB32:
                begin
                    fmt_next = FMT_ULEB;
                    sr_next  = {32'd0, src_data.value[31:0]};
                end
                MODE_ULEB64:
                begin
                    fmt_next = FMT_ULEB;
                    sr_next  = src_data.value;
                end
                MODE_SLEB32:
                begin
                    fmt_next = FMT_SLEB;
                    sr_next  = {{32{src_data.value[31]}}, src_data.value[31:0]};
                end
                MODE_SLEB64:
                begin
                    fmt_next = FMT_SLEB;
                    sr_next  = src_data.value;
                end
                default:
                begin
                    fmt_next = FMT_BE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            dst_valid_reg <= 1'b0;
            fmt_reg       <= FMT_BE;
        end
        else
        begin
            busy_reg      <= busy_next;
            dst_valid_reg <= dst_valid_next;
            fmt_reg       <= fmt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg       <= sr_next;
        cnt_reg      <= cnt_next;
        dst_data_reg <= dst_data_next;
    end

    // an accepted item always starts a run
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted transaction did not start a run");

    // a new byte appears only while a run is active
    a_byte_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> $past(busy_reg))
        else $error("byte emitted with no active run");

    // a run ends only with a flagged final byte in the output register
    a_run_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> (dst_valid && dst_data.last))
        else $error("run ended without a final byte");

    // a big-endian count never wraps while its run is active
    a_be_count: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && fmt_reg == FMT_BE && cnt_reg == 3'd0) |=> !busy_reg || $past(accept))
        else $error("big-endian run overran its byte count");

endmodule

FILE: test/vbsleb_checker.sv
// ----------------------------------------------------------------------------
// vbsleb_checker
// watches both channels of the value byte serializer and checks every byte
// ----------------------------------------------------------------------------
// Each accepted source transaction is expanded into the byte run the block
// should emit. Each accepted destination transaction is compared with the
// oldest byte still waiting.
module vbsleb_checker
    import vbsleb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    input  logic      src_ready,
    input  src_item_t src_data,
    input  logic      dst_valid,
    input  logic      dst_ready,
    input  dst_item_t dst_data,
    output int        errors,
    output int        pending,
    output int        items_seen,
    output int        bytes_seen
);

    dst_item_t expected_bytes[$];

    initial
    begin
        errors     = 0;
        pending    = 0;
        items_seen = 0;
        bytes_seen = 0;
    end

    function automatic void add_byte(input logic [BYTE_W-1:0] b, input logic fin);
        dst_item_t entry;
        entry.out_byte = b;
        entry.last     = fin;
        expected_bytes.push_back(entry);
    endfunction

    // expands one source item into its serialized byte run
    function automatic void predict_run(input src_item_t item);
        logic [VALUE_W-1:0] rest;
        logic [BYTE_W-1:0]  digit;
        logic               done;
        int                 nbytes;
        mode_t              fmt;
        fmt = mode_t'(item.mode);
        case (fmt)
            MODE_BYTE, MODE_BE16, MODE_BE32, MODE_BE64:
            begin
                // byte, be16, be32, be64 are 1, 2, 4, 8 bytes, msb first
                nbytes = 1 << item.mode;
                for (int i = nbytes - 1; i >= 0; i--)
                begin
                    add_byte(item.value[BYTE_W*i +: BYTE_W], i == 0);
                end
            end
            MODE_ULEB32, MODE_ULEB64:
            begin
                rest = (fmt == MODE_ULEB32) ? {32'd0, item.value[31:0]} : item.value;
                done = 1'b0;
                while (!done)
                begin
                    digit = {1'b0, rest[DIGIT_W-1:0]};
                    rest  = rest >> DIGIT_W;
                    done  = (rest == '0);
                    if (!done)
                    begin
                        digit = digit | LEB_MORE;
                    end
                    add_byte(digit, done);
                end
            end
            default:
            begin
                // signed forms: sleb32 sign-extends the low word first
                rest = (fmt == MODE_SLEB32) ?
                       {{32{item.value[31]}}, item.value[31:0]} : item.value;
                done = 1'b0;
                while (!done)
                begin
                    digit = {1'b0, rest[DIGIT_W-1:0]};
                    rest  = $signed(rest) >>> DIGIT_W;
                    done  = (rest == '0 && !digit[DIGIT_W-1]) ||
                            (rest == '1 && digit[DIGIT_W-1]);
                    if (!done)
                    begin
                        digit = digit | LEB_MORE;
                    end
                    add_byte(digit, done);
                end
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        dst_item_t want;
        if (rst_n)
        begin
            if (src_valid && src_ready)
            begin
                predict_run(src_data);
                items_seen++;
            end
            if (dst_valid && dst_ready)
            begin
                bytes_seen++;
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected byte transaction: out_byte %02h last %0b",
                           dst_data.out_byte, dst_data.last);
                    errors++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (dst_data.out_byte !== want.out_byte)
                    begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.out_byte, dst_data.out_byte);
                        errors++;
                    end
                    if (dst_data.last !== want.last)
                    begin
                        $error("last mismatch: expected %0b, actual %0b",
                               want.last, dst_data.last);
                        errors++;
                    end
                end
            end
            pending = expected_bytes.size();
        end
    end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for value_byte_serializer_leb128
// ----------------------------------------------------------------------------
// Sends a directed set of values through every format, then random values
// with random modes. Both channels idle at random; a quiet stretch in the
// middle runs at full rate. A separate checker predicts and compares bytes.
module testbench;
    import vbsleb_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 155;
    localparam int TAIL_CYCLES  = 24;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_ready;
    src_item_t src_data  = '0;
    logic      dst_valid;
    logic      dst_ready = 1'b0;
    dst_item_t dst_data;

    // when set, neither side idles
    logic      quiet     = 1'b0;

    int        errors;
    int        pending;
    int        items_seen;
    int        bytes_seen;
    int        cycle_count = 0;
    int        sink_gap;
    int        sink_wait   = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    value_byte_serializer_leb128 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data)
    );

    vbsleb_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .src_data   (src_data),
        .dst_valid  (dst_valid),
        .dst_ready  (dst_ready),
        .dst_data   (dst_data),
        .errors     (errors),
        .pending    (pending),
        .items_seen (items_seen),
        .bytes_seen (bytes_seen)
    );

    // gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 40)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // value shapes: full random, random bit length, small, small negative,
    // and values near the 32-bit sign boundary with junk in the high word
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        int                 kind;
        v    = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: ;
            4, 5, 6:    v = v >> $urandom_range(0, 63);
            7:          v = 64'($urandom_range(0, 300));
            8:          v = ~(v >> $urandom_range(0, 63));
            default:
            begin
                v[31:0] = v[31:0] >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1)
                begin
                    v[31:0] = ~v[31:0];
                end
            end
        endcase
        return v;
    endfunction

    // one source transaction: optional gap, then hold valid until accepted.
    // ready is looked at on the falling edge so the check never races the dut
    task automatic send_item(input mode_t fmt, input logic [VALUE_W-1:0] v);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid      <= 1'b1;
        src_data.mode  <= fmt;
        src_data.value <= v;
        @(negedge clk);
        while (!src_ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // sink: ready drops for random stretches
    always @(posedge clk)
    begin
        if (sink_wait != 0)
        begin
            sink_wait <= sink_wait - 1;
            dst_ready <= (sink_wait == 1);
        end
        else
        begin
            sink_gap  = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
            sink_wait <= sink_gap;
            dst_ready <= (sink_gap == 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** value_byte_serializer_leb128: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes and the edges of every format
        send_item(MODE_BYTE,   64'h0);
        send_item(MODE_BYTE,   64'hFFFF_FFFF_FFFF_FFFF);
        send_item(MODE_BE16,   64'hA5A5_0000_0000_1234);
        send_item(MODE_BE32,   64'hFFFF_FFFF_0000_0000);
        send_item(MODE_BE64,   64'h0123_4567_89AB_CDEF);
        send_item(MODE_BE64,   64'hFFFF_FFFF_FFFF_FFFF);
        // uleb32: zero gives one byte, high word ignored, group boundary
        send_item(MODE_ULEB32, 64'h0);
        send_item(MODE_ULEB32, 64'hDEAD_BEEF_FFFF_FFFF);
        send_item(MODE_ULEB32, 64'h7F);
        send_item(MODE_ULEB32, 64'h80);
        // uleb64: zero, longest run, top bit alone
        send_item(MODE_ULEB64, 64'h0);
        send_item(MODE_ULEB64, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(MODE_ULEB64, 64'h8000_0000_0000_0000);
        // sleb32: sign bit 0x40 decides the stop on both sides of zero
        send_item(MODE_SLEB32, 64'h0);
        send_item(MODE_SLEB32, 64'h0000_0000_FFFF_FFFF);
        send_item(MODE_SLEB32, 64'h3F);
        send_item(MODE_SLEB32, 64'h40);
        send_item(MODE_SLEB32, 64'h0000_0000_FFFF_FFC0);
        send_item(MODE_SLEB32, 64'h0000_0000_FFFF_FFBF);
        send_item(MODE_SLEB32, 64'h1234_5678_8000_0000);
        send_item(MODE_SLEB32, 64'hFFFF_FFFF_7FFF_FFFF);
        // sleb64: minus one, most negative, most positive, just past -64
        send_item(MODE_SLEB64, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(MODE_SLEB64, 64'h8000_0000_0000_0000);
        send_item(MODE_SLEB64, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(MODE_SLEB64, 64'hFFFF_FFFF_FFFF_FFBF);

        // random modes and shaped values; a stretch in the middle at full rate
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet <= (n >= 60 && n < 100);
            send_item(mode_t'(3'($urandom_range(0, 7))), random_value());
        end
        src_valid <= 1'b0;
        quiet     <= 1'b0;

        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d source transactions across all eight formats",
                 items_seen);
        $display("and %0d byte transactions with random stalls on both sides",
                 bytes_seen);
        if (errors == 0 && pending == 0)
        begin
            $display("** value_byte_serializer_leb128: PASSED **");
        end
        else
        begin
            $display("** value_byte_serializer_leb128: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/vbsleb_pkg.sv
sv/value_byte_serializer_leb128.sv
test/vbsleb_checker.sv
test/testbench.sv
